>>> sv/fact_pkg.sv
// Shared types, codes and constants of the frame acknowledgement credit tracker.
package fact_pkg;

   // Field widths of the request and response payloads, the configuration port and the latency sum.
   localparam int TS_W    = 40;
   localparam int LAT_W   = 32;
   localparam int SUM_W   = 64;
   localparam int CNT8_W  = 8;
   localparam int DEPTH_W = 6;
   localparam int OUT_W   = 7;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 6;

   // Default ring size and register reset values.
   localparam int RING_DEPTH_DEFAULT = 64;
   localparam logic                ENABLE_RESET  = 1'b1;
   localparam logic [DEPTH_W-1:0]  MAX_OUT_RESET = 6'd4;

   // Operation codes.
   localparam logic [2:0] OP_DELIVER   = 3'd0;
   localparam logic [2:0] OP_ACK       = 3'd1;
   localparam logic [2:0] OP_RECONCILE = 3'd2;
   localparam logic [2:0] OP_FLUSH     = 3'd3;
   localparam logic [2:0] OP_STATS     = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_OUT = 2'd1;

   typedef struct packed {
      logic [2:0]          opcode;
      logic [TS_W-1:0]     now_ms;
      logic [CNT8_W-1:0]   ack_count;
      logic [DEPTH_W-1:0]  hook_queue_depth;
   } req_type;

   typedef struct packed {
      logic [CNT8_W-1:0]   acks_to_forward;
      logic [CNT8_W-1:0]   discarded_now;
      logic                ring_was_full;
      logic [OUT_W-1:0]    outstanding;
      logic [LAT_W-1:0]    latency_samples;
      logic [LAT_W-1:0]    latency_avg_ms;
      logic [LAT_W-1:0]    latency_max_ms;
      logic [LAT_W-1:0]    discarded_total;
      logic [LAT_W-1:0]    presumed_dropped_total;
      logic [LAT_W-1:0]    overflow_total;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic op_start;
      logic ack_age;
      logic ack_acc;
      logic rec_apply;
      logic result_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [2:0] opcode;
      logic       ack_empty;
      logic       ack_last;
      logic       div_busy;
   } sts_type;

endpackage

>>> sv/fact_ctrl.sv
// Controller state machine that sequences each request through the datapath.
module fact_ctrl
   import fact_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_DECODE  = 3'd1;
   localparam logic [2:0] S_ACK_RD  = 3'd2;
   localparam logic [2:0] S_ACK_AGE = 3'd3;
   localparam logic [2:0] S_ACK_ACC = 3'd4;
   localparam logic [2:0] S_REC     = 3'd5;
   localparam logic [2:0] S_DIV     = 3'd6;
   localparam logic [2:0] S_FIN     = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.op_start = 1'b1;
            unique case (sts.opcode)
               OP_ACK:       state_in = sts.ack_empty ? S_FIN : S_ACK_RD;
               OP_RECONCILE: state_in = S_REC;
               OP_STATS:     state_in = S_DIV;
               default:      state_in = S_FIN;
            endcase
         end
         S_ACK_RD:  state_in = S_ACK_AGE;
         S_ACK_AGE: begin
            cmd.ack_age = 1'b1;
            state_in    = S_ACK_ACC;
         end
         S_ACK_ACC: begin
            cmd.ack_acc = 1'b1;
            state_in    = sts.ack_last ? S_FIN : S_ACK_RD;
         end
         S_REC: begin
            cmd.rec_apply = 1'b1;
            state_in      = S_FIN;
         end
         S_DIV: begin
            if (!sts.div_busy) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.result_load = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> sv/fact_div.sv
// Restoring divider, one quotient bit per cycle, for the mean latency.
module fact_div
   import fact_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [LAT_W-1:0] divisor,
   output logic             busy,
   output logic [SUM_W-1:0] quotient
);

   localparam int STEP_W = $clog2(SUM_W);

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [LAT_W-1:0]  rem_ff, rem_in;
   logic [LAT_W-1:0]  dvsr_ff, dvsr_in;
   logic [LAT_W:0]    rem_sh;
   logic              ge;

   assign busy     = busy_ff;
   assign quotient = quo_ff;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[SUM_W-1]};
      ge      = (rem_sh >= {1'b0, dvsr_ff});
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = STEP_W'(SUM_W - 1);
         quo_in  = dividend;
         rem_in  = '0;
         dvsr_in = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[SUM_W-2:0], ge};
         rem_in = ge ? LAT_W'(rem_sh - {1'b0, dvsr_ff}) : LAT_W'(rem_sh);
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
   end

endmodule

>>> sv/fact_dp.sv
// Datapath: timestamp ring, latency statistics, running counters and result register.
module fact_dp
   import fact_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  req_type              req_data,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   input  cmd_type              cmd,
   output sts_type              sts,
   output rsp_type              rsp_data
);

   localparam int IW = $clog2(RING_DEPTH);
   localparam int FW = $clog2(RING_DEPTH + 1);
   localparam int CW = (FW > CNT8_W) ? FW : CNT8_W;

   logic [TS_W-1:0] mem [RING_DEPTH];
   logic [TS_W-1:0] rdata_ff;

   req_type            req_ff, req_in;
   logic               enable_ff, enable_in;
   logic [DEPTH_W-1:0] max_out_ff, max_out_in;
   logic [IW-1:0]      head_ff, head_in;
   logic [FW-1:0]      fill_ff, fill_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [LAT_W-1:0]   peak_ff, peak_in;
   logic [LAT_W-1:0]   tally_ff, tally_in;
   logic [LAT_W-1:0]   disc_cnt_ff, disc_cnt_in;
   logic [LAT_W-1:0]   drop_cnt_ff, drop_cnt_in;
   logic [LAT_W-1:0]   ovf_cnt_ff, ovf_cnt_in;
   logic [CNT8_W-1:0]  left_ff, left_in;
   logic [LAT_W-1:0]   ms_ff, ms_in;
   logic [FW-1:0]      released_ff, released_in;
   logic [CNT8_W-1:0]  fwd_ff, fwd_in;
   logic [CNT8_W-1:0]  disc_now_ff, disc_now_in;
   logic               full_ff, full_in;
   logic [LAT_W-1:0]   samples_ff, samples_in;
   logic [LAT_W-1:0]   peak_snap_ff, peak_snap_in;
   rsp_type            rsp_ff, rsp_in;

   logic               mem_we;
   logic [IW-1:0]      wr_addr;
   logic [IW:0]        wr_sum;
   logic [IW:0]        rec_sum;
   logic [IW-1:0]      rec_head;
   logic [IW-1:0]      head_inc;
   logic [CNT8_W-1:0]  n_ack;
   logic [DEPTH_W:0]   limit;
   logic [CW-1:0]      rel_full;
   logic [FW-1:0]      released_val;
   logic [TS_W-1:0]    age;
   logic [LAT_W-1:0]   age_ms;
   logic               div_start;
   logic               div_busy;
   logic [SUM_W-1:0]   div_quo;
   logic [LAT_W-1:0]   avg_sat;

   fact_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (tally_ff),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   assign div_start = cmd.op_start && (req_ff.opcode == OP_STATS);

   assign sts.opcode    = req_ff.opcode;
   assign sts.ack_empty = (req_ff.ack_count == '0) || (fill_ff == '0);
   assign sts.ack_last  = (left_ff == CNT8_W'(1));
   assign sts.div_busy  = div_busy;

   assign rsp_data = rsp_ff;

   always_comb begin
      wr_sum   = (IW+1)'(head_ff) + (IW+1)'(fill_ff);
      wr_addr  = (wr_sum >= (IW+1)'(RING_DEPTH)) ? IW'(wr_sum - (IW+1)'(RING_DEPTH))
                                                  : IW'(wr_sum);
      rec_sum  = (IW+1)'(head_ff) + (IW+1)'(released_ff);
      rec_head = (rec_sum >= (IW+1)'(RING_DEPTH)) ? IW'(rec_sum - (IW+1)'(RING_DEPTH))
                                                   : IW'(rec_sum);
      head_inc = (head_ff == IW'(RING_DEPTH - 1)) ? '0 : head_ff + IW'(1);

      n_ack = (CW'(req_ff.ack_count) < CW'(fill_ff)) ? req_ff.ack_count
                                                      : CNT8_W'(fill_ff);

      limit        = (DEPTH_W+1)'(max_out_ff) + (DEPTH_W+1)'(req_ff.hook_queue_depth);
      rel_full     = CW'(fill_ff) - CW'(limit);
      released_val = (enable_ff && (CW'(fill_ff) > CW'(limit))) ? FW'(rel_full) : '0;

      age    = (req_ff.now_ms > rdata_ff) ? (req_ff.now_ms - rdata_ff) : '0;
      age_ms = (|age[TS_W-1:LAT_W]) ? '1 : age[LAT_W-1:0];

      avg_sat = (|div_quo[SUM_W-1:LAT_W]) ? '1 : div_quo[LAT_W-1:0];
   end

   always_comb begin
      req_in       = req_ff;
      enable_in    = enable_ff;
      max_out_in   = max_out_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      peak_in      = peak_ff;
      tally_in     = tally_ff;
      disc_cnt_in  = disc_cnt_ff;
      drop_cnt_in  = drop_cnt_ff;
      ovf_cnt_in   = ovf_cnt_ff;
      left_in      = left_ff;
      ms_in        = ms_ff;
      released_in  = released_ff;
      fwd_in       = fwd_ff;
      disc_now_in  = disc_now_ff;
      full_in      = full_ff;
      samples_in   = samples_ff;
      peak_snap_in = peak_snap_ff;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_ENABLE:  enable_in  = csr_wdata[0];
            CSR_MAX_OUT: max_out_in = csr_wdata[DEPTH_W-1:0];
            default: ;
         endcase
      end

      if (cmd.load_req) begin
         req_in = req_data;
      end

      if (cmd.op_start) begin
         fwd_in       = '0;
         disc_now_in  = '0;
         full_in      = 1'b0;
         samples_in   = '0;
         peak_snap_in = '0;
         unique case (req_ff.opcode)
            OP_DELIVER: begin
               if (fill_ff >= FW'(RING_DEPTH)) begin
                  ovf_cnt_in = ovf_cnt_ff + LAT_W'(1);
                  full_in    = 1'b1;
               end else begin
                  mem_we  = 1'b1;
                  fill_in = fill_ff + FW'(1);
               end
            end
            OP_ACK: begin
               left_in     = n_ack;
               disc_now_in = req_ff.ack_count - n_ack;
               disc_cnt_in = disc_cnt_ff + LAT_W'(req_ff.ack_count - n_ack);
               fwd_in      = enable_ff ? n_ack : req_ff.ack_count;
            end
            OP_RECONCILE: begin
               released_in = released_val;
            end
            OP_FLUSH: begin
               fwd_in  = enable_ff ? CNT8_W'(fill_ff) : '0;
               head_in = '0;
               fill_in = '0;
            end
            OP_STATS: begin
               samples_in   = tally_ff;
               peak_snap_in = peak_ff;
               tally_in     = '0;
               sum_in       = '0;
               peak_in      = '0;
            end
            default: ;
         endcase
      end

      if (cmd.ack_age) begin
         ms_in = age_ms;
      end

      if (cmd.ack_acc) begin
         sum_in   = sum_ff + SUM_W'(ms_ff);
         peak_in  = (ms_ff > peak_ff) ? ms_ff : peak_ff;
         tally_in = tally_ff + LAT_W'(1);
         head_in  = head_inc;
         fill_in  = fill_ff - FW'(1);
         left_in  = left_ff - CNT8_W'(1);
      end

      if (cmd.rec_apply) begin
         head_in     = rec_head;
         fill_in     = fill_ff - released_ff;
         drop_cnt_in = drop_cnt_ff + LAT_W'(released_ff);
         fwd_in      = CNT8_W'(released_ff);
      end

      if (cmd.result_load) begin
         rsp_in.acks_to_forward        = fwd_ff;
         rsp_in.discarded_now          = disc_now_ff;
         rsp_in.ring_was_full          = full_ff;
         rsp_in.outstanding            = OUT_W'(fill_ff);
         rsp_in.latency_samples        = samples_ff;
         rsp_in.latency_avg_ms         = (samples_ff != '0) ? avg_sat : '0;
         rsp_in.latency_max_ms         = peak_snap_ff;
         rsp_in.discarded_total        = disc_cnt_ff;
         rsp_in.presumed_dropped_total = drop_cnt_ff;
         rsp_in.overflow_total         = ovf_cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= req_ff.now_ms;
      end
      rdata_ff <= mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= ENABLE_RESET;
         max_out_ff  <= MAX_OUT_RESET;
         head_ff     <= '0;
         fill_ff     <= '0;
         sum_ff      <= '0;
         peak_ff     <= '0;
         tally_ff    <= '0;
         disc_cnt_ff <= '0;
         drop_cnt_ff <= '0;
         ovf_cnt_ff  <= '0;
      end else begin
         enable_ff   <= enable_in;
         max_out_ff  <= max_out_in;
         head_ff     <= head_in;
         fill_ff     <= fill_in;
         sum_ff      <= sum_in;
         peak_ff     <= peak_in;
         tally_ff    <= tally_in;
         disc_cnt_ff <= disc_cnt_in;
         drop_cnt_ff <= drop_cnt_in;
         ovf_cnt_ff  <= ovf_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      left_ff      <= left_in;
      ms_ff        <= ms_in;
      released_ff  <= released_in;
      fwd_ff       <= fwd_in;
      disc_now_ff  <= disc_now_in;
      full_ff      <= full_in;
      samples_ff   <= samples_in;
      peak_snap_ff <= peak_snap_in;
      rsp_ff       <= rsp_in;
   end

endmodule

>>> sv/frame_ack_credit_tracker.sv
// Top level of the frame acknowledgement credit tracker.
//
// The tracker keeps a ring of send timestamps, one for each delivered frame
// that has not been acknowledged, and answers every request with exactly one
// response. Requests are handled one at a time. An ack batch pops ring
// entries one by one: every pop reads the timestamp memory through its
// registered read port, then forms the entry's age, then adds it to the
// latency statistics. A stats read waits for the divider that forms the mean
// latency one quotient bit per cycle over a 64-bit sum. A new request is taken
// while the previous response still waits in the output register; the tracker
// only holds back at the end of a request when that register is still occupied.
// The configuration port is always ready and must only be written while the
// tracker is idle.
module frame_ack_credit_tracker
   import fact_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,

   // Request channel.
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,

   // Response channel.
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,

   // Configuration write channel.
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   // Register writes complete in the cycle they are presented.
   assign csr_ready = 1'b1;

   // The controller walks each request through decode, the per-entry pop
   // loop, the reconcile step or the divider wait, and then the response.
   fact_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the ring memory, the statistics, the running
   // counters and the response register.
   fact_dp #(
      .RING_DEPTH (RING_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule

>>> sv/fact_chk.sv
// Port-level checker for the frame acknowledgement credit tracker, with its bind.
module fact_chk
   import fact_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input req_type              req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input rsp_type              rsp_data,
   input logic                 csr_valid,
   input logic                 csr_ready,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [CSR_DAT_W-1:0] csr_wdata
);

   // A pending response holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed or dropped while stalled");

   // Requests are worked one at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in progress");

   // A refused delivery returns no credit and discards nothing.
   a_full_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.ring_was_full |->
         rsp_data.acks_to_forward == '0 && rsp_data.discarded_now == '0)
      else $error("full-ring response carries credit or discards");

   // Discarded acks mean the batch emptied the ring.
   a_discard_empties: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.discarded_now != '0 |-> rsp_data.outstanding == '0)
      else $error("acks discarded while frames remain outstanding");

   // No samples gives a zero mean.
   a_avg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.latency_samples == '0 |-> rsp_data.latency_avg_ms == '0)
      else $error("nonzero mean latency without samples");

endmodule

bind frame_ack_credit_tracker fact_chk u_fact_chk (.*);
